/* hw/rtl/tvs_pkg.sv */
// Shared types, constants and helpers of the trilinear volume sampler.
// No dependencies.
package tvs_pkg;

	localparam int FRAC_BITS = 8;
	localparam int INT_BITS  = 5;
	localparam int COORD_W   = FRAC_BITS + INT_BITS;
	localparam int DIM_W     = 6;
	localparam int DIM_MAX   = 32;
	localparam int ADDR_W    = 15;
	localparam int MEM_DEPTH = 32768;
	localparam int VAL_W     = 16;
	localparam int ROW_W     = 10;
	localparam int PLANE_W   = 11;
	localparam int VOL_W     = 16;
	localparam int WT_W      = FRAC_BITS + 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int NCORNER   = 8;
	localparam int RAM_COPIES = 4;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CLAMP = 2'd1,
		ST_DROP  = 2'd2
	} status_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;

	typedef struct packed {
		logic [INT_BITS-1:0]  lo;
		logic [INT_BITS-1:0]  hi;
		logic [FRAC_BITS-1:0] frac;
		logic                 clamped;
	} axis_t;

	// one classified item as it crosses from front to back
	typedef struct packed {
		op_t                  op;
		status_t              status;
		logic                 we;
		logic [ADDR_W-1:0]    widx;
		logic [VAL_W-1:0]     val;
		logic [INT_BITS-1:0]  xlo;
		logic [INT_BITS-1:0]  xhi;
		logic [ROW_W-1:0]     ylo_off;
		logic [ROW_W-1:0]     yhi_off;
		logic [ADDR_W-1:0]    zlo_off;
		logic [ADDR_W-1:0]    zhi_off;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic [FRAC_BITS-1:0] fz;
	} entry_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		d = r;
		if (r == '0)
			d = DIM_W'(1);
		else if (r > DIM_W'(DIM_MAX))
			d = DIM_W'(DIM_MAX);
		return d;
	endfunction

	function automatic axis_t split_axis(input logic [COORD_W-1:0] c,
		input logic [DIM_W-1:0] dim);
		axis_t a;
		logic [INT_BITS-1:0] ip;
		ip = c[COORD_W-1:FRAC_BITS];
		a.clamped = 1'b0;
		a.lo = ip;
		a.frac = c[FRAC_BITS-1:0];
		if ({1'b0, ip} >= dim) begin
			a.lo = INT_BITS'(dim - DIM_W'(1));
			a.frac = '0;
			a.clamped = 1'b1;
		end
		if (({1'b0, a.lo} + DIM_W'(1)) < dim)
			a.hi = a.lo + INT_BITS'(1);
		else
			a.hi = a.lo;
		return a;
	endfunction

endpackage

/* hw/rtl/tvs_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on tvs_pkg for field widths.
interface tvs_req_if;
	import tvs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [ADDR_W-1:0]    voxel_index;
	logic signed [VAL_W-1:0] voxel_value;
	logic [COORD_W-1:0]   x_coord;
	logic [COORD_W-1:0]   y_coord;
	logic [COORD_W-1:0]   z_coord;
	modport source(output valid, operation, voxel_index, voxel_value,
		x_coord, y_coord, z_coord, input ready);
	modport sink(input valid, operation, voxel_index, voxel_value,
		x_coord, y_coord, z_coord, output ready);
endinterface

interface tvs_rsp_if;
	import tvs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] sample_value;
	logic [1:0]              status;
	modport source(output valid, sample_value, status, input ready);
	modport sink(input valid, sample_value, status, output ready);
endinterface

/* hw/rtl/trilinear_volume_sampler_core.sv */
// Top level of the trilinear volume sampler: front end, queue, back end.
// Depends on tvs_pkg, tvs_if, tvs_front, tvs_queue, tvs_back.
//
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | operation, voxel_index, voxel_value, x/y/z_coord
//  rsp     | out | valid/ready     | sample_value, status
//  cfg     | in  | cfg_we          | cfg_index, cfg_data
//
// One beat per cycle sustained while rsp is ready; the store is four copies
// with two read ports each, so all eight corners are read in the same cycle.
// The path runs through 2 front stages, the queue and 5 back stages.
// Reset sets each dimension to 32; the voxel store is not cleared.
// A stalled rsp holds the back end; the 4-entry queue keeps req flowing until it fills.
module trilinear_volume_sampler_core import tvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	tvs_req_if.sink          req,
	tvs_rsp_if.source        rsp
);

	logic   push, pop, full, empty;
	entry_t push_data, pop_data;

	tvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.q_full    (full),
		.push      (push),
		.push_data (push_data)
	);

	tvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

/* hw/rtl/tvs_front.sv */
// Front end: config registers, request intake, coordinate clamp and
// row/plane offsets. Depends on tvs_pkg and tvs_req_if.
module tvs_front import tvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	tvs_req_if.sink           req,
	input  logic              q_full,
	output logic              push,
	output entry_t            push_data
);

	logic [DIM_W-1:0]   w_q, h_q, d_q;
	logic [PLANE_W-1:0] wh_q;
	logic [VOL_W-1:0]   whd_q;

	logic               vld_s1;
	op_t                op_s1;
	logic [ADDR_W-1:0]  widx_s1;
	logic [VAL_W-1:0]   val_s1;
	axis_t              ax_s1, ay_s1, az_s1;

	logic               vld_s2;
	entry_t             ent_s2;

	axis_t              ax_d, ay_d, az_d;
	logic               adv;
	logic               in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= DIM_W'(DIM_MAX);
			h_q   <= DIM_W'(DIM_MAX);
			d_q   <= DIM_W'(DIM_MAX);
			wh_q  <= PLANE_W'(DIM_MAX * DIM_MAX);
			whd_q <= VOL_W'(MEM_DEPTH);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  w_q <= eff_dim(cfg_data);
					REG_HEIGHT: h_q <= eff_dim(cfg_data);
					REG_DEPTH:  d_q <= eff_dim(cfg_data);
					default: ;
				endcase
			end
			wh_q  <= PLANE_W'(w_q) * PLANE_W'(h_q);
			whd_q <= VOL_W'(wh_q) * VOL_W'(d_q);
		end
	end

	assign adv       = !vld_s2 || !q_full;
	assign req.ready = adv;

	always_comb begin
		ax_d = split_axis(req.x_coord, w_q);
		ay_d = split_axis(req.y_coord, h_q);
		az_d = split_axis(req.z_coord, d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op_t'(req.operation);
			widx_s1 <= req.voxel_index;
			val_s1  <= req.voxel_value;
			ax_s1   <= ax_d;
			ay_s1   <= ay_d;
			az_s1   <= az_d;

			ent_s2.op      <= op_s1;
			ent_s2.status  <= (ax_s1.clamped || ay_s1.clamped || az_s1.clamped)
				? ST_CLAMP : ST_OK;
			ent_s2.we      <= 1'b0;
			ent_s2.widx    <= widx_s1;
			ent_s2.val     <= val_s1;
			ent_s2.xlo     <= ax_s1.lo;
			ent_s2.xhi     <= ax_s1.hi;
			ent_s2.ylo_off <= ROW_W'(ay_s1.lo) * ROW_W'(w_q);
			ent_s2.yhi_off <= ROW_W'(ay_s1.hi) * ROW_W'(w_q);
			ent_s2.zlo_off <= ADDR_W'(az_s1.lo) * ADDR_W'(wh_q);
			ent_s2.zhi_off <= ADDR_W'(az_s1.hi) * ADDR_W'(wh_q);
			ent_s2.fx      <= ax_s1.frac;
			ent_s2.fy      <= ay_s1.frac;
			ent_s2.fz      <= az_s1.frac;
		end
	end

	// write range check sits here so it sees the settled volume size
	assign in_range = {1'b0, ent_s2.widx} < whd_q;

	always_comb begin
		push_data = ent_s2;
		if (ent_s2.op == OP_WRITE) begin
			push_data.we     = in_range;
			push_data.status = in_range ? ST_OK : ST_DROP;
		end
	end

	assign push = vld_s2 && !q_full;

endmodule

/* hw/rtl/tvs_queue.sv */
// Four-entry queue between the front and back ends.
// Depends on tvs_pkg.
module tvs_queue import tvs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	entry_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QPTR_W:0]    cnt_q;

	assign full     = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || full) |-> wptr_q == rptr_q)
		else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/tvs_back.sv */
// Back end: corner addresses, replicated voxel store, three lerp stages
// and rounding into the result register. Depends on tvs_pkg, tvs_rsp_if.
module tvs_back import tvs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t pop_data,
	input  logic   empty,
	output logic   pop,
	tvs_rsp_if.source rsp
);

	localparam int XL_W = VAL_W + FRAC_BITS + 1;
	localparam int YL_W = XL_W + FRAC_BITS + 1;
	localparam int ZL_W = YL_W + FRAC_BITS + 1;
	localparam int RND  = 3 * FRAC_BITS;
	localparam logic [WT_W-1:0] ONE = WT_W'(1 << FRAC_BITS);

	logic adv;

	logic                    vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [ADDR_W-1:0]       addr_s3 [NCORNER];
	logic                    we_s3;
	logic [ADDR_W-1:0]       widx_s3;
	logic [VAL_W-1:0]        val_s3;
	op_t                     op_s3, op_s4, op_s5, op_s6;
	status_t                 st_s3, st_s4, st_s5, st_s6;
	logic [FRAC_BITS-1:0]    fx_s3, fy_s3, fz_s3, fx_s4, fy_s4, fz_s4;
	logic [FRAC_BITS-1:0]    fy_s5, fz_s5, fz_s6;

	logic [VAL_W-1:0]        mem_q [RAM_COPIES][MEM_DEPTH];
	logic signed [VAL_W-1:0] rd_s4 [NCORNER];
	logic signed [XL_W-1:0]  xl_s5 [4];
	logic signed [YL_W-1:0]  yl_s6 [2];
	logic signed [VAL_W-1:0] value_s7;
	logic [1:0]              status_s7;

	logic [ADDR_W-1:0]       addr_d [NCORNER];
	logic signed [XL_W-1:0]  xl_d [4];
	logic signed [YL_W-1:0]  yl_d [2];
	logic signed [ZL_W-1:0]  zl_d;
	logic signed [WT_W:0]    wx0, wx1, wy0, wy1, wz0, wz1;

	assign adv = !vld_s7 || rsp.ready;
	assign pop = adv && !empty;

	always_comb begin
		for (int n = 0; n < NCORNER; n++) begin
			addr_d[n] = ADDR_W'(n[0] ? pop_data.xhi : pop_data.xlo)
				+ ADDR_W'(n[1] ? pop_data.yhi_off : pop_data.ylo_off)
				+ (n[2] ? pop_data.zhi_off : pop_data.zlo_off);
		end
	end

	always_comb begin
		wx0 = {1'b0, ONE - WT_W'(fx_s4)};
		wx1 = {2'b0, fx_s4};
		wy0 = {1'b0, ONE - WT_W'(fy_s5)};
		wy1 = {2'b0, fy_s5};
		wz0 = {1'b0, ONE - WT_W'(fz_s6)};
		wz1 = {2'b0, fz_s6};
		for (int j = 0; j < 4; j++)
			xl_d[j] = rd_s4[2*j] * wx0 + rd_s4[2*j+1] * wx1;
		for (int j = 0; j < 2; j++)
			yl_d[j] = xl_s5[2*j] * wy0 + xl_s5[2*j+1] * wy1;
		zl_d = yl_s6[0] * wz0 + yl_s6[1] * wz1 + ZL_W'(1 << (RND - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= pop;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s3 <= addr_d;
			we_s3   <= pop_data.we;
			widx_s3 <= pop_data.widx;
			val_s3  <= pop_data.val;
			op_s3   <= pop_data.op;
			st_s3   <= pop_data.status;
			fx_s3   <= pop_data.fx;
			fy_s3   <= pop_data.fy;
			fz_s3   <= pop_data.fz;

			op_s4 <= op_s3;
			st_s4 <= st_s3;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;

			xl_s5 <= xl_d;
			op_s5 <= op_s4;
			st_s5 <= st_s4;
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;

			yl_s6 <= yl_d;
			op_s6 <= op_s5;
			st_s6 <= st_s5;
			fz_s6 <= fz_s5;

			value_s7  <= (op_s6 == OP_SAMPLE) ? zl_d[RND+VAL_W-1:RND] : '0;
			status_s7 <= st_s6;
		end
	end

	// each copy: one write port, two read ports
	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			for (int k = 0; k < RAM_COPIES; k++) begin
				if (we_s3)
					mem_q[k][widx_s3] <= val_s3;
				rd_s4[2*k]   <= mem_q[k][addr_s3[2*k]];
				rd_s4[2*k+1] <= mem_q[k][addr_s3[2*k+1]];
			end
		end
	end

	assign rsp.valid        = vld_s7;
	assign rsp.sample_value = value_s7;
	assign rsp.status       = status_s7;

	a_drop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && st_s3 == ST_DROP) |-> !we_s3)
		else $error("dropped write reaches the store");
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && $past(adv) && $past(vld_s6) && $past(op_s6) == OP_WRITE)
		|-> value_s7 == '0)
		else $error("write beat carries a nonzero value");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && !rsp.ready) |=> vld_s7 && $stable(value_s7))
		else $error("result lost under stall");

endmodule
